### hw/rtl/gtf_pkg.sv
// shared types and constants for the mode to crtc timing block
`timescale 1ns / 1ps

package gtf_pkg;

   // number of register writes per mode
   localparam int WRITES = 20;

   // register indexes
   localparam logic [4:0] CR_HTOTAL   = 5'h00;
   localparam logic [4:0] CR_HDISP    = 5'h01;
   localparam logic [4:0] CR_HBSTART  = 5'h02;
   localparam logic [4:0] CR_HBEND    = 5'h03;
   localparam logic [4:0] CR_HSSTART  = 5'h04;
   localparam logic [4:0] CR_HSEND    = 5'h05;
   localparam logic [4:0] CR_VTOTAL   = 5'h06;
   localparam logic [4:0] CR_OVERFLOW = 5'h07;
   localparam logic [4:0] CR_MAXSCAN  = 5'h09;
   localparam logic [4:0] CR_VSSTART  = 5'h10;
   localparam logic [4:0] CR_VSEND    = 5'h11;
   localparam logic [4:0] CR_VDEND    = 5'h12;
   localparam logic [4:0] CR_OFFSET   = 5'h13;
   localparam logic [4:0] CR_VBSTART  = 5'h15;
   localparam logic [4:0] CR_VBEND    = 5'h16;
   localparam logic [4:0] CR_MODE     = 5'h17;
   localparam logic [4:0] CR_LINECMP  = 5'h18;
   localparam logic [4:0] EX_SCREEN   = 5'd25;
   localparam logic [4:0] EX_HORIZ    = 5'd26;
   localparam logic [4:0] EX_EXTRA    = 5'd27;

   // write order of one run
   localparam logic [4:0] SEL_TAB [WRITES] = '{
      CR_HTOTAL, CR_HDISP, CR_HBSTART, CR_HBEND, CR_HSSTART, CR_HSEND, CR_VTOTAL,
      CR_OVERFLOW, CR_MAXSCAN, CR_VSSTART, CR_VSEND, CR_VDEND, CR_OFFSET, CR_VBSTART,
      CR_VBEND, CR_MODE, CR_LINECMP, EX_SCREEN, EX_HORIZ, EX_EXTRA
   };

   // fixed register contents
   localparam logic [7:0] MODE_VALUE    = 8'hc3;
   localparam logic [7:0] LINECMP_VALUE = 8'hff;

   // timing constants
   localparam logic [19:0] MICRO_PER_SEC = 20'd1000000;
   localparam logic [9:0]  MIN_VSBP_US   = 10'd550;
   localparam logic [25:0] MIN_VSBP_Q16  = 26'd36044800;
   localparam logic [35:0] MICRO_Q16     = 36'd65536000000;
   localparam logic [21:0] CPRIME_Q16    = 22'd1966080;
   localparam logic [22:0] HUNDRED_Q16   = 23'd6553600;
   localparam logic [18:0] KHZ_MAX       = 19'd500000;

   // reciprocals for the constant divisions, exact over the operand ranges
   localparam logic [24:0] RECIP10        = 25'd26843546;
   localparam int          RECIP10_SHIFT  = 28;
   localparam logic [12:0] RECIP100       = 13'd5243;
   localparam int          RECIP100_SHIFT = 19;

   // mode bounds
   localparam logic [11:0] W_MIN = 12'd320;
   localparam logic [11:0] W_MAX = 12'd2048;
   localparam logic [11:0] H_MIN = 12'd200;
   localparam logic [11:0] H_MAX = 12'd2048;
   localparam logic [6:0]  R_MIN = 7'd50;
   localparam logic [6:0]  R_MAX = 7'd120;

   // timing context carried down the pipeline
   typedef struct packed {
      logic [11:0] w;
      logic [11:0] h;
      logic [6:0]  r;
      logic        deep;
      logic [22:0] hpe;
      logic [11:0] vtot;
      logic [22:0] hp;
      logic [20:0] duty;
      logic [9:0]  hblank;
      logic [11:0] htot;
      logic [9:0]  clk_q;
   } cx_type;

   // counters handed to the write sequencer
   typedef struct packed {
      logic [11:0] ht;
      logic [11:0] hd;
      logic [11:0] hs;
      logic [11:0] he;
      logic [11:0] hbe;
      logic [11:0] vt;
      logic [11:0] vd;
      logic [11:0] vs;
      logic [11:0] ve;
      logic [11:0] vbe;
      logic [7:0]  pitch;
      logic [18:0] khz;
   } crtc_type;

endpackage

### hw/rtl/gtf_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module gtf_div #(
   parameter int NUM_W  = 37,
   parameter int DEN_W  = 18,
   parameter int QUO_W  = 23,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [QUO_W];
   logic [DEN_W-1:0]  rem_ff   [QUO_W];
   logic [QUO_W-1:0]  bits_ff  [QUO_W];
   logic [DEN_W-1:0]  den_ff   [QUO_W];
   logic [SIDE_W-1:0] side_ff  [QUO_W];
   logic [NUM_W-1:0]  num_hi;

   // upper dividend bits are already below the divisor
   assign num_hi = in_num >> QUO_W;

   for (genvar i = 0; i < QUO_W; i++) begin : g_step
      logic              src_valid;
      logic [DEN_W-1:0]  src_rem;
      logic [QUO_W-1:0]  src_bits;
      logic [DEN_W-1:0]  src_den;
      logic [SIDE_W-1:0] src_side;
      logic [DEN_W:0]    trial;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;

      if (i == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_rem   = num_hi[DEN_W-1:0];
         assign src_bits  = in_num[QUO_W-1:0];
         assign src_den   = in_den;
         assign src_side  = in_side;
      end else begin : g_next
         assign src_valid = valid_ff[i-1];
         assign src_rem   = rem_ff[i-1];
         assign src_bits  = bits_ff[i-1];
         assign src_den   = den_ff[i-1];
         assign src_side  = side_ff[i-1];
      end

      // trial subtract of one shifted-in bit
      assign trial  = {src_rem, src_bits[QUO_W-1]};
      assign ge     = trial >= {1'b0, src_den};
      assign rem_in = ge ? DEN_W'(trial - {1'b0, src_den}) : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            bits_ff[i] <= {src_bits[QUO_W-2:0], ge};
            den_ff[i]  <= src_den;
            side_ff[i] <= src_side;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = bits_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

### hw/rtl/gtf_ser.sv
// write sequencer: turns one timing set into twenty register writes
`timescale 1ns / 1ps

module gtf_ser
   import gtf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  crtc_type    in_crtc,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_reg_select,
   output logic [7:0]  rsp_reg_value,
   output logic [18:0] rsp_pixel_clock_khz,
   output logic        rsp_last_write
);

   logic        item_valid_ff;
   logic [4:0]  idx_ff;
   crtc_type    crtc_ff;
   logic        out_valid_ff;
   logic [4:0]  out_sel_ff;
   logic [7:0]  out_val_ff;
   logic [18:0] out_khz_ff;
   logic        out_last_ff;

   logic        out_move;
   logic        emit;
   logic        last_slot;
   logic        load;
   logic [4:0]  sel_cur;
   logic [7:0]  val_cur;

   // handshake between held item and output register
   assign out_move  = !out_valid_ff || !rsp_stall;
   assign emit      = item_valid_ff && out_move;
   assign last_slot = idx_ff == 5'(WRITES - 1);
   assign in_ready  = !item_valid_ff || (emit && last_slot);
   assign load      = in_valid && in_ready;
   assign sel_cur   = SEL_TAB[idx_ff];

   // register byte packing
   always_comb begin
      unique case (sel_cur)
         CR_HTOTAL:   val_cur = crtc_ff.ht[7:0];
         CR_HDISP:    val_cur = crtc_ff.hd[7:0];
         CR_HBSTART:  val_cur = crtc_ff.hd[7:0];
         CR_HBEND:    val_cur = {3'b100, crtc_ff.hbe[4:0]};
         CR_HSSTART:  val_cur = crtc_ff.hs[7:0];
         CR_HSEND:    val_cur = {crtc_ff.hbe[5], 2'b00, crtc_ff.he[4:0]};
         CR_VTOTAL:   val_cur = crtc_ff.vt[7:0];
         CR_OVERFLOW: val_cur = {crtc_ff.vs[9], crtc_ff.vd[9], crtc_ff.vt[9], 1'b1,
                                 crtc_ff.vd[8], crtc_ff.vs[8], crtc_ff.vd[8],
                                 crtc_ff.vt[8]};
         CR_MAXSCAN:  val_cur = {2'b01, crtc_ff.vd[9], 5'b00000};
         CR_VSSTART:  val_cur = crtc_ff.vs[7:0];
         CR_VSEND:    val_cur = {4'b0010, crtc_ff.ve[3:0]};
         CR_VDEND:    val_cur = crtc_ff.vd[7:0];
         CR_OFFSET:   val_cur = crtc_ff.pitch;
         CR_VBSTART:  val_cur = crtc_ff.vd[7:0];
         CR_VBEND:    val_cur = crtc_ff.vbe[7:0];
         CR_MODE:     val_cur = MODE_VALUE;
         CR_LINECMP:  val_cur = LINECMP_VALUE;
         EX_SCREEN:   val_cur = {3'b000, crtc_ff.hbe[6], crtc_ff.vd[10], crtc_ff.vs[10],
                                 crtc_ff.vd[10], crtc_ff.vt[10]};
         EX_HORIZ:    val_cur = {4'b0000, crtc_ff.hs[8], crtc_ff.hd[8], crtc_ff.hd[8],
                                 crtc_ff.ht[8]};
         EX_EXTRA:    val_cur = {1'b0, crtc_ff.vd[11], 1'b0, crtc_ff.vs[11], 1'b0,
                                 crtc_ff.vd[11], 1'b0, crtc_ff.vt[11]};
         default:     val_cur = 8'h00;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         idx_ff        <= 5'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (out_move) begin
            out_valid_ff <= item_valid_ff;
         end
         if (load) begin
            item_valid_ff <= 1'b1;
            idx_ff        <= 5'd0;
         end else if (emit) begin
            idx_ff <= last_slot ? 5'd0 : idx_ff + 5'd1;
            if (last_slot) begin
               item_valid_ff <= 1'b0;
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (load) begin
         crtc_ff <= in_crtc;
      end
      if (emit) begin
         out_sel_ff  <= sel_cur;
         out_val_ff  <= val_cur;
         out_khz_ff  <= crtc_ff.khz;
         out_last_ff <= last_slot;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_reg_select      = out_sel_ff;
   assign rsp_reg_value       = out_val_ff;
   assign rsp_pixel_clock_khz = out_khz_ff;
   assign rsp_last_write      = out_last_ff;

endmodule

### hw/rtl/gtf_mode_timing_to_crtc_top.sv
// top level: gtf timing pipeline and register write sequencer
`timescale 1ns / 1ps

// Mode to CRTC timing block.
// req channel: one display mode per item (width, height, refresh, depth).
// rsp channel: twenty register writes per mode, in ascending register order,
// each with index, byte value and the pixel clock in kHz; last_write marks
// the twentieth.
// The timing math runs in a fully pipelined chain of restoring dividers, one
// quotient bit per stage, with short add and multiply stages between them;
// the divisions by 10 and by 100 are single reciprocal multiply stages.
// An accepted mode passes the pipeline registers to the write sequencer, which
// holds it and registers each of its writes onto the rsp ports.
// A new mode may enter every cycle while req_stall is low, but the sequencer
// gives one write per cycle while rsp_stall is low, so the sustained mode rate
// is set by the single rsp port.
// Reset clears all valid bits and the sequencer; no item is in flight after.
// When rsp_stall is high the output write holds and the sequencer stops; the
// pipeline keeps moving until its last stage holds a mode, then freezes and
// req_stall rises. Nothing is lost.

module gtf_mode_timing_to_crtc_top
   import gtf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_mode_width,
   input  logic [11:0] req_mode_height,
   input  logic [6:0]  req_refresh_hz,
   input  logic        req_deep_color,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_reg_select,
   output logic [7:0]  rsp_reg_value,
   output logic [18:0] rsp_pixel_clock_khz,
   output logic        rsp_last_write
);

   logic adv;
   logic ser_ready;

   // stage valids
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff;
   logic v11_ff, v12_ff, v13_ff, v14_ff, v15_ff, v16_ff, v17_ff;
   logic vd_ff, vg_ff;
   logic va, vb, vc, ve, vf;

   // stage context
   cx_type cx1_ff, cx2_ff, cx3_ff, cx4_ff, cx5_ff, cx6_ff, cx7_ff, cx8_ff, cx9_ff;
   cx_type cx10_ff, cx11_ff, cx12_ff, cx13_ff, cx14_ff, cx15_ff, cx16_ff;
   cx_type cxd_ff, cxg_ff;
   cx_type cxa, cxb, cxc, cxe, cxf;
   cx_type cx1_in;

   logic [17:0] dena2_ff, dena3_ff;
   logic [19:0] base2_ff;
   logic [36:0] numa3_ff;
   logic [22:0] qa;
   logic [25:0] numb4_ff;
   logic [22:0] denb4_ff;
   logic [7:0]  qb;
   logic [18:0] denc6_ff, denc7_ff;
   logic [35:0] numc7_ff;
   logic [22:0] qc;
   logic [24:0] numd8_ff;
   logic [49:0] drop_prod;
   logic [21:0] qd_ff;
   logic [32:0] prod10_ff, nume11_ff;
   logic [22:0] sube10_ff;
   logic [26:0] dene11_ff;
   logic [5:0]  qe;
   logic [27:0] numf13_ff;
   logic [22:0] denf13_ff;
   logic [9:0]  qf;
   logic [11:0] numg14_ff;
   logic [24:0] sync_prod;
   logic [4:0]  qg_ff;
   logic [19:0] khz_full;
   logic [18:0] khz15_ff, khz16_ff;
   logic [7:0]  hsync15_ff;
   logic [11:0] half15_ff;
   logic [11:0] hss16_ff, hse16_ff;
   crtc_type    crtc17_ff;

   // pipeline moves unless the last stage is full and the sequencer is busy
   assign adv       = !v17_ff || ser_ready;
   assign req_stall = !adv;

   // clamp the mode fields
   always_comb begin
      cx1_in      = '0;
      cx1_in.w    = (req_mode_width < W_MIN) ? W_MIN :
                    ((req_mode_width > W_MAX) ? W_MAX : req_mode_width);
      cx1_in.h    = (req_mode_height < H_MIN) ? H_MIN :
                    ((req_mode_height > H_MAX) ? H_MAX : req_mode_height);
      cx1_in.r    = (req_refresh_hz < R_MIN) ? R_MIN :
                    ((req_refresh_hz > R_MAX) ? R_MAX : req_refresh_hz);
      cx1_in.deep = req_deep_color;
   end

   // valid bits of the glue stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         vd_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
         v12_ff <= 1'b0;
         v13_ff <= 1'b0;
         v14_ff <= 1'b0;
         vg_ff  <= 1'b0;
         v15_ff <= 1'b0;
         v16_ff <= 1'b0;
         v17_ff <= 1'b0;
      end else if (adv) begin
         v1_ff  <= req_valid;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= va;
         v5_ff  <= vb;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= vc;
         vd_ff  <= v8_ff;
         v9_ff  <= vd_ff;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
         v12_ff <= ve;
         v13_ff <= v12_ff;
         v14_ff <= vf;
         vg_ff  <= v14_ff;
         v15_ff <= vg_ff;
         v16_ff <= v15_ff;
         v17_ff <= v16_ff;
      end
   end

   // estimated line period: operands
   always_ff @(posedge clock) begin
      if (adv) begin
         cx1_ff   <= cx1_in;
         cx2_ff   <= cx1_ff;
         dena2_ff <= 18'(18'(cx1_ff.r) * (18'(cx1_ff.h) + 18'd1));
         base2_ff <= MICRO_PER_SEC - 20'(20'(cx1_ff.r) * 20'(MIN_VSBP_US));
         cx3_ff   <= cx2_ff;
         numa3_ff <= 37'({base2_ff, 16'h0000}) + 37'(dena2_ff >> 1);
         dena3_ff <= dena2_ff;
      end
   end

   gtf_div #(.NUM_W(37), .DEN_W(18), .QUO_W(23), .SIDE_W($bits(cx_type))) u_div_hpe (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(v3_ff), .in_num(numa3_ff), .in_den(dena3_ff), .in_side(cx3_ff),
      .out_valid(va), .out_quo(qa), .out_side(cxa)
   );

   // vertical sync plus back porch
   always_ff @(posedge clock) begin
      if (adv) begin
         cx4_ff     <= cxa;
         cx4_ff.hpe <= qa;
         numb4_ff   <= MIN_VSBP_Q16 + 26'(qa >> 1);
         denb4_ff   <= qa;
      end
   end

   gtf_div #(.NUM_W(26), .DEN_W(23), .QUO_W(8), .SIDE_W($bits(cx_type))) u_div_vsbp (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(v4_ff), .in_num(numb4_ff), .in_den(denb4_ff), .in_side(cx4_ff),
      .out_valid(vb), .out_quo(qb), .out_side(cxb)
   );

   // total lines and line period operands
   always_ff @(posedge clock) begin
      if (adv) begin
         cx5_ff      <= cxb;
         cx5_ff.vtot <= cxb.h + 12'(qb) + 12'd1;
         cx6_ff      <= cx5_ff;
         denc6_ff    <= 19'(19'(cx5_ff.r) * 19'(cx5_ff.vtot));
         cx7_ff      <= cx6_ff;
         numc7_ff    <= MICRO_Q16 + 36'(denc6_ff >> 1);
         denc7_ff    <= denc6_ff;
      end
   end

   gtf_div #(.NUM_W(36), .DEN_W(19), .QUO_W(23), .SIDE_W($bits(cx_type))) u_div_hp (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(v7_ff), .in_num(numc7_ff), .in_den(denc7_ff), .in_side(cx7_ff),
      .out_valid(vc), .out_quo(qc), .out_side(cxc)
   );

   // duty drop is (3 hp + 5) / 10
   always_ff @(posedge clock) begin
      if (adv) begin
         cx8_ff    <= cxc;
         cx8_ff.hp <= qc;
         numd8_ff  <= 25'(25'(qc) * 25'd3) + 25'd5;
      end
   end

   // divide by 10 through the reciprocal
   assign drop_prod = 50'(numd8_ff) * 50'(RECIP10);

   always_ff @(posedge clock) begin
      if (adv) begin
         cxd_ff <= cx8_ff;
         qd_ff  <= 22'(drop_prod >> RECIP10_SHIFT);
      end
   end

   // duty cycle, floored at zero, and blank operands
   always_ff @(posedge clock) begin
      if (adv) begin
         cx9_ff      <= cxd_ff;
         cx9_ff.duty <= (qd_ff < CPRIME_Q16) ? 21'(CPRIME_Q16 - qd_ff) : 21'd0;
         cx10_ff     <= cx9_ff;
         prod10_ff   <= 33'(33'(cx9_ff.w) * 33'(cx9_ff.duty));
         sube10_ff   <= HUNDRED_Q16 - 23'(cx9_ff.duty);
         cx11_ff     <= cx10_ff;
         nume11_ff   <= prod10_ff + 33'({sube10_ff, 3'b000});
         dene11_ff   <= {sube10_ff, 4'b0000};
      end
   end

   gtf_div #(.NUM_W(33), .DEN_W(27), .QUO_W(6), .SIDE_W($bits(cx_type))) u_div_blank (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(v11_ff), .in_num(nume11_ff), .in_den(dene11_ff), .in_side(cx11_ff),
      .out_valid(ve), .out_quo(qe), .out_side(cxe)
   );

   // horizontal total and pixel clock operands
   always_ff @(posedge clock) begin
      if (adv) begin
         cx12_ff        <= cxe;
         cx12_ff.hblank <= {qe, 4'b0000};
         cx12_ff.htot   <= cxe.w + 12'({qe, 4'b0000});
         cx13_ff        <= cx12_ff;
         numf13_ff      <= {cx12_ff.htot, 16'h0000} + 28'(cx12_ff.hp >> 1);
         denf13_ff      <= cx12_ff.hp;
      end
   end

   gtf_div #(.NUM_W(28), .DEN_W(23), .QUO_W(10), .SIDE_W($bits(cx_type))) u_div_clk (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(v13_ff), .in_num(numf13_ff), .in_den(denf13_ff), .in_side(cx13_ff),
      .out_valid(vf), .out_quo(qf), .out_side(cxf)
   );

   // sync width is 8 * round(htot / 100)
   always_ff @(posedge clock) begin
      if (adv) begin
         cx14_ff       <= cxf;
         cx14_ff.clk_q <= qf;
         numg14_ff     <= cxf.htot + 12'd50;
      end
   end

   // divide by 100 through the reciprocal
   assign sync_prod = 25'(numg14_ff) * 25'(RECIP100);

   always_ff @(posedge clock) begin
      if (adv) begin
         cxg_ff <= cx14_ff;
         qg_ff  <= 5'(sync_prod >> RECIP100_SHIFT);
      end
   end

   assign khz_full = 20'(20'(cxg_ff.clk_q) * 20'd1000);

   // sync placement and register counters
   always_ff @(posedge clock) begin
      if (adv) begin
         cx15_ff    <= cxg_ff;
         khz15_ff   <= (khz_full > 20'(KHZ_MAX)) ? KHZ_MAX : khz_full[18:0];
         hsync15_ff <= {qg_ff, 3'b000};
         half15_ff  <= cxg_ff.w + 12'(cxg_ff.hblank >> 1);
         cx16_ff    <= cx15_ff;
         khz16_ff   <= khz15_ff;
         hss16_ff   <= (half15_ff >= 12'(hsync15_ff)) ? half15_ff - 12'(hsync15_ff) : 12'd0;
         hse16_ff   <= (half15_ff >= 12'(hsync15_ff)) ? half15_ff : 12'(hsync15_ff);
         crtc17_ff.ht    <= 12'(cx16_ff.htot >> 3) - 12'd5;
         crtc17_ff.hd    <= 12'(cx16_ff.w >> 3) - 12'd1;
         crtc17_ff.hs    <= 12'(hss16_ff >> 3) - 12'd1;
         crtc17_ff.he    <= 12'(hse16_ff >> 3) - 12'd1;
         crtc17_ff.hbe   <= 12'(cx16_ff.htot >> 3) - 12'd1;
         crtc17_ff.vt    <= cx16_ff.vtot - 12'd2;
         crtc17_ff.vd    <= cx16_ff.h - 12'd1;
         crtc17_ff.vs    <= cx16_ff.h;
         crtc17_ff.ve    <= cx16_ff.h + 12'd3;
         crtc17_ff.vbe   <= cx16_ff.vtot - 12'd1;
         crtc17_ff.pitch <= cx16_ff.deep ? {cx16_ff.w[8:3], 2'b00} : {cx16_ff.w[9:3], 1'b0};
         crtc17_ff.khz   <= khz16_ff;
      end
   end

   gtf_ser u_ser (
      .clock(clock), .reset(reset),
      .in_valid(v17_ff), .in_ready(ser_ready), .in_crtc(crtc17_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_reg_select(rsp_reg_select), .rsp_reg_value(rsp_reg_value),
      .rsp_pixel_clock_khz(rsp_pixel_clock_khz), .rsp_last_write(rsp_last_write)
   );

   // a run ends on the last extension register
   a_last_reg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_write |-> rsp_reg_select == EX_EXTRA)
      else $error("last write not on final register");

   // a run continues without gaps
   a_run_dense: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_write |=> rsp_valid)
      else $error("gap inside a run of writes");

   // the next run starts on the first register
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_write |=> !rsp_valid || rsp_reg_select == CR_HTOTAL)
      else $error("run does not start on first register");

   // pipeline freezes only behind a full last stage
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v17_ff && !ser_ready)
      else $error("pipeline stalled without cause");

endmodule
